>>> hdl/sxbp_pkg.sv
// package with constants, codes and the read stage type of the signed xor block permuter
package sxbp_pkg;

    localparam int MAX_LOG_BLOCK = 10;
    localparam int BANK_AW       = MAX_LOG_BLOCK;
    localparam int STORE_AW      = BANK_AW + 1;
    localparam int STORE_DEPTH   = 1 << STORE_AW;
    localparam int CNT_W         = 11;
    localparam int IDX_W         = 15;
    localparam int LOG_W         = 4;
    localparam int NLEN_W        = 16;
    localparam int WORD_W        = 64;
    localparam int HALF_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 15;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CONFIG = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INCOMPLETE = 2'd2;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LOG_BLOCK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XOR_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_SIGN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_WORDS  = 3'd4;

    // item in flight between the store read and the output register
    typedef struct packed {
        logic                has_word;
        logic                flip;
        logic                wide;
        logic [IDX_W-1:0]    index;
        logic [STATUS_W-1:0] status;
        logic                last;
    } read_stage_t;

endpackage

>>> hdl/signed_xor_block_permute_core.sv
// top level of the signed xor block permuter with ping-pong word store
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | cmd, in_word
//  output   | out_valid / out_stall| out_word, out_index, status, block_end
//  config   | cfg_we               | cfg_index, cfg_data
//
// one item per cycle while the output does not stall: the item reads its source
// word from the store at the accept edge and the registered read data is
// shaped and put into the output register when the read stage moves on.
// the only stall source is a full, stalled output register with the read stage busy.
// reset clears counters, bank select, pending flag and config; the store itself
// is not cleared: the user must write entries before they are read, the block does not enforce it.
module signed_xor_block_permute_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic [sxbp_pkg::WORD_W-1:0]          in_word,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sxbp_pkg::WORD_W-1:0]          out_word,
    output logic [sxbp_pkg::IDX_W-1:0]           out_index,
    output logic [sxbp_pkg::STATUS_W-1:0]        status,
    output logic                                 block_end,
    input  logic                                 cfg_we,
    input  logic [sxbp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sxbp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sxbp_pkg::*;

    // configuration registers
    logic [LOG_W-1:0] log_block_reg;
    logic [IDX_W-1:0] xor_offset_reg;
    logic [IDX_W-1:0] sign_mask_reg;
    logic             global_sign_reg;
    logic             wide_words_reg;

    // control state
    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic [CNT_W-1:0] emit_count_reg, emit_count_next;
    logic             pending_reg, pending_next;
    logic             fill_bank_reg, fill_bank_next;

    // read stage and output register
    read_stage_t      rs_reg, rs_next;
    logic             rs_valid_reg, rs_valid_next;
    logic             rs_move;
    logic             out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [STATUS_W-1:0] status_reg;
    logic             block_end_reg;

    // word store
    logic [WORD_W-1:0]   store [STORE_DEPTH];
    logic [WORD_W-1:0]   rdata_reg;
    logic [STORE_AW-1:0] waddr, raddr;
    logic [WORD_W-1:0]   wdata;
    logic                mem_we, mem_re;

    logic              accept;
    logic [NLEN_W-1:0] n_full;
    logic [CNT_W-1:0]  n_len;
    logic              cfg_ok;
    logic [CNT_W-1:0]  src_j;
    logic [CNT_W-1:0]  emit_inc;
    logic [CNT_W-1:0]  fill_inc;
    logic              emitted;
    logic [WORD_W-1:0] shaped;

    // the read stage empties when the output register is free or leaving
    assign rs_move  = rs_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = rs_valid_reg && !rs_move;
    assign accept   = in_valid && !in_stall;

    assign n_full = NLEN_W'(1) << log_block_reg;
    assign n_len  = n_full[CNT_W-1:0];
    assign cfg_ok = (log_block_reg >= LOG_W'(1)) && (log_block_reg <= LOG_W'(MAX_LOG_BLOCK))
                    && ({1'b0, (xor_offset_reg | sign_mask_reg)} < n_full);

    assign src_j    = emit_count_reg ^ xor_offset_reg[CNT_W-1:0];
    assign emit_inc = emit_count_reg + CNT_W'(1);
    assign fill_inc = fill_count_reg + CNT_W'(1);

    // source word from the pending bank, the one not being filled
    assign raddr = {~fill_bank_reg, src_j[BANK_AW-1:0]};
    assign waddr = {fill_bank_reg, fill_count_reg[BANK_AW-1:0]};
    assign wdata = wide_words_reg ? in_word : {{HALF_W{1'b0}}, in_word[HALF_W-1:0]};

    always_comb
    begin
        fill_count_next = fill_count_reg;
        emit_count_next = emit_count_reg;
        pending_next    = pending_reg;
        fill_bank_next  = fill_bank_reg;
        rs_next         = rs_reg;
        rs_valid_next   = rs_valid_reg && !rs_move;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        emitted         = 1'b0;

        if (accept) begin
            rs_next.has_word = 1'b0;
            rs_next.flip     = 1'b0;
            rs_next.wide     = wide_words_reg;
            rs_next.index    = '0;
            rs_next.status   = STATUS_OK;
            rs_next.last     = 1'b0;

            if (!cfg_ok) begin
                rs_next.status = STATUS_BAD_CONFIG;
                rs_valid_next  = 1'b1;
            end else begin
                // emission of the next pending word
                if (pending_reg) begin
                    if (emit_count_reg >= n_len) begin
                        pending_next    = 1'b0;
                        emit_count_next = '0;
                    end else begin
                        emitted          = 1'b1;
                        mem_re           = 1'b1;
                        rs_next.has_word = 1'b1;
                        rs_next.flip     = global_sign_reg
                                           ^ (^(sign_mask_reg[BANK_AW-1:0]
                                                & src_j[BANK_AW-1:0]));
                        rs_next.index    = IDX_W'(emit_count_reg);
                        rs_next.last     = (emit_count_reg == (n_len - CNT_W'(1)));
                        rs_valid_next    = 1'b1;
                        if (emit_inc >= n_len) begin
                            pending_next    = 1'b0;
                            emit_count_next = '0;
                        end else begin
                            emit_count_next = emit_inc;
                        end
                    end
                end

                if (cmd == CMD_PUSH) begin
                    mem_we          = 1'b1;
                    fill_count_next = fill_inc;
                    // a full block becomes pending, a still pending one is dropped
                    if (fill_inc >= n_len) begin
                        fill_count_next = '0;
                        fill_bank_next  = ~fill_bank_reg;
                        pending_next    = 1'b1;
                        emit_count_next = '0;
                    end
                end else if (!emitted && (fill_count_reg != '0)) begin
                    // drain with a partial block: discard it and report
                    fill_count_next = '0;
                    rs_next.status  = STATUS_INCOMPLETE;
                    rs_valid_next   = 1'b1;
                end
            end
        end
    end

    // sign bit 63 in wide mode, bit 31 otherwise
    always_comb
    begin
        shaped = rs_reg.wide ? rdata_reg : {{HALF_W{1'b0}}, rdata_reg[HALF_W-1:0]};
        if (rs_reg.wide) begin
            shaped[WORD_W-1] = shaped[WORD_W-1] ^ rs_reg.flip;
        end else begin
            shaped[HALF_W-1] = shaped[HALF_W-1] ^ rs_reg.flip;
        end
        if (!rs_reg.has_word) begin
            shaped = '0;
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            store[waddr] <= wdata;
        end
        if (mem_re) begin
            rdata_reg <= store[raddr];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            log_block_reg   <= LOG_W'(1);
            xor_offset_reg  <= '0;
            sign_mask_reg   <= '0;
            global_sign_reg <= 1'b0;
            wide_words_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LOG_BLOCK:   log_block_reg   <= cfg_data[LOG_W-1:0];
                REG_XOR_OFFSET:  xor_offset_reg  <= cfg_data[IDX_W-1:0];
                REG_SIGN_MASK:   sign_mask_reg   <= cfg_data[IDX_W-1:0];
                REG_GLOBAL_SIGN: global_sign_reg <= cfg_data[0];
                REG_WIDE_WORDS:  wide_words_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_count_reg <= '0;
            emit_count_reg <= '0;
            pending_reg    <= 1'b0;
            fill_bank_reg  <= 1'b0;
            rs_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            emit_count_reg <= emit_count_next;
            pending_reg    <= pending_next;
            fill_bank_reg  <= fill_bank_next;
            rs_valid_reg   <= rs_valid_next;
            if (rs_move) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rs_reg <= rs_next;
        if (rs_move) begin
            out_word_reg  <= shaped;
            out_index_reg <= rs_reg.index;
            status_reg    <= rs_reg.status;
            block_end_reg <= rs_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_index = out_index_reg;
    assign status    = status_reg;
    assign block_end = block_end_reg;

endmodule

>>> tb/testbench.sv
// self-checking testbench of the signed xor block permuter top level
module testbench;

    import sxbp_pkg::*;

    // largest block size that the valid random phases use
    localparam int TOP_LOG = 6;

    // one expected output item of the permuter
    typedef struct {
        bit [WORD_W-1:0]   word;
        bit [IDX_W-1:0]    index;
        bit [STATUS_W-1:0] code;
        bit                last;
    } permute_result_t;

    // scoreboard: mirrors the ping-pong store, counters and registers, and holds
    // the output items still owed by the block, oldest first
    class permute_scoreboard;
        bit [WORD_W-1:0]    word_store [0:STORE_DEPTH-1];
        bit [CNT_W-1:0]     fill_count;
        bit [CNT_W-1:0]     emit_count;
        bit                 pending;
        bit                 fill_bank;
        bit [LOG_W-1:0]     log_block;
        bit [IDX_W-1:0]     xor_offset;
        bit [IDX_W-1:0]     sign_mask;
        bit                 global_sign;
        bit                 wide;
        permute_result_t    due_results [$];
        int                 errors;
        int                 seen;

        function new();
            log_block = 1;
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_LOG_BLOCK:   log_block   = val[LOG_W-1:0];
                REG_XOR_OFFSET:  xor_offset  = val;
                REG_SIGN_MASK:   sign_mask   = val;
                REG_GLOBAL_SIGN: global_sign = val[0];
                REG_WIDE_WORDS:  wide        = val[0];
                default: ;
            endcase
        endfunction

        function bit config_ok();
            if (log_block < 1 || log_block > MAX_LOG_BLOCK)
                return 0;
            return int'(xor_offset | sign_mask) < (1 << log_block);
        endfunction

        function bit has_pending();
            return pending;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function void owe(bit [WORD_W-1:0] w, bit [IDX_W-1:0] idx, bit [STATUS_W-1:0] code,
                          bit last);
            permute_result_t r;
            r.word  = w;
            r.index = idx;
            r.code  = code;
            r.last  = last;
            due_results.push_back(r);
        endfunction

        // next output of the pending block; returns 1 when one was produced
        function bit emit_next(int unsigned n);
            bit [BANK_AW-1:0] src;
            bit [WORD_W-1:0]  w;
            bit               flip;
            if (!pending)
                return 0;
            if (emit_count >= n)
            begin
                pending    = 0;
                emit_count = 0;
                return 0;
            end
            src  = emit_count[BANK_AW-1:0] ^ xor_offset[BANK_AW-1:0];
            w    = word_store[{~fill_bank, src}];
            flip = global_sign ^ (^(sign_mask[BANK_AW-1:0] & src));
            if (wide)
                w[63] ^= flip;
            else
            begin
                w[63:32] = '0;
                w[31] ^= flip;
            end
            owe(w, IDX_W'(emit_count), STATUS_OK, emit_count == n - 1);
            emit_count++;
            if (emit_count >= n)
            begin
                pending    = 0;
                emit_count = 0;
            end
            return 1;
        endfunction

        // accepted input item: update the mirror and note the output it causes
        function void take_item(bit op, bit [WORD_W-1:0] data);
            int unsigned n;
            if (!config_ok())
            begin
                owe('0, '0, STATUS_BAD_CONFIG, 1'b0);
                return;
            end
            n = 1 << log_block;
            if (op == CMD_PUSH)
            begin
                if (!wide)
                    data[63:32] = '0;
                word_store[{fill_bank, fill_count[BANK_AW-1:0]}] = data;
                fill_count++;
                void'(emit_next(n));
                if (fill_count >= n)
                begin
                    fill_count = 0;
                    fill_bank  = ~fill_bank;
                    pending    = 1;
                    emit_count = 0;
                end
            end
            else if (!emit_next(n) && fill_count != 0)
            begin
                fill_count = 0;
                owe('0, '0, STATUS_INCOMPLETE, 1'b0);
            end
        endfunction

        function void match_result(logic [WORD_W-1:0] w, logic [IDX_W-1:0] idx,
                                   logic [STATUS_W-1:0] code, logic last);
            permute_result_t want;
            seen++;
            if (due_results.size() == 0)
            begin
                report($sformatf("item %0d not expected: word %h index %0d status %0d",
                                 seen, w, idx, code));
                return;
            end
            want = due_results.pop_front();
            if (w !== want.word)
                report($sformatf("item %0d word %h, want %h", seen, w, want.word));
            if (idx !== want.index)
                report($sformatf("item %0d index %0d, want %0d", seen, idx, want.index));
            if (code !== want.code)
                report($sformatf("item %0d status %0d, want %0d", seen, code, want.code));
            if (last !== want.last)
                report($sformatf("item %0d block_end %b, want %b", seen, last, want.last));
        endfunction

        function void close_out();
            if (due_results.size() != 0)
                report($sformatf("%0d items never arrived", due_results.size()));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cmd;
    logic [WORD_W-1:0]     in_word;
    logic                  out_valid;
    logic                  out_stall;
    logic [WORD_W-1:0]     out_word;
    logic [IDX_W-1:0]      out_index;
    logic [STATUS_W-1:0]   status;
    logic                  block_end;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    permute_scoreboard sb;

    // calm flags give stretches with no idling on each side
    bit in_calm;
    bit out_calm;
    int stall_left;
    int sent;

    signed_xor_block_permute_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .out_index (out_index),
        .status    (status),
        .block_end (block_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard limit, far above the slowest correct run
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    // wait before the next item or result, random outside calm phases, which come and go
    function automatic int pick_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 7));
    endfunction

    // half of the time random words, else all ones, zero or a lone sign bit
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h0000_0000_8000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // offset or mask below the block length, with the edge values favored
    function automatic logic [IDX_W-1:0] pick_below(int n);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return IDX_W'(n - 1);
            default: return IDX_W'($urandom_range(0, n - 1));
        endcase
    endfunction

    // result side: sample at the rising edge, then draw the stall before the next item
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.match_result(out_word, out_index, status, block_end);
            stall_left = pick_wait(out_calm);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // one input item; entered just after a rising edge, returns at its accept edge
    task automatic send_item(logic op, logic [WORD_W-1:0] data);
        int gap;
        gap = pick_wait(in_calm);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        in_word  <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_item(op, data);
        sent++;
    endtask

    task automatic push_words(int count);
        repeat (count) send_item(CMD_PUSH, pick_word());
    endtask

    task automatic drain_words(int count);
        repeat (count) send_item(CMD_DRAIN, pick_word());
    endtask

    // empties the pending block; only with a valid configuration
    task automatic drain_pending();
        while (sb.has_pending())
            send_item(CMD_DRAIN, pick_word());
    endtask

    // sender pauses until every owed item is out, then covers the read latency
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // all five registers, written back to back while the block is idle
    task automatic configure(logic [LOG_W-1:0] lb, logic [IDX_W-1:0] off,
                             logic [IDX_W-1:0] mask, logic gs, logic ww);
        settle();
        write_reg(REG_LOG_BLOCK, CFG_DATA_W'(lb));
        write_reg(REG_XOR_OFFSET, off);
        write_reg(REG_SIGN_MASK, mask);
        write_reg(REG_GLOBAL_SIGN, CFG_DATA_W'(gs));
        write_reg(REG_WIDE_WORDS, CFG_DATA_W'(ww));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int target;
        int n;
        int blocks;
        int waited;
        logic [LOG_W-1:0] lb;
        logic [IDX_W-1:0] off;
        logic [IDX_W-1:0] mask;

        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_PUSH;
        in_word    = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_LOG_BLOCK;
        cfg_data   = '0;
        stall_left = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both banks completely at the largest valid block size used below,
        // so that no later block length or offset can read a store entry that was
        // never written
        configure(LOG_W'(TOP_LOG), IDX_W'($urandom_range(0, (1 << TOP_LOG) - 1)),
                  IDX_W'($urandom_range(0, (1 << TOP_LOG) - 1)),
                  1'($urandom_range(0, 1)), 1'b1);
        push_words(2 << TOP_LOG);
        drain_pending();

        // narrow words, offset and mask at their top, global sign set
        configure(2, 3, 3, 1'b1, 1'b0);
        push_words(4);
        drain_words(4);
        // drain with nothing at all: no item
        drain_words(1);
        // drain finding a partial block
        push_words(1);
        drain_words(1);

        // wide words at the smallest block
        configure(1, 1, 1, 1'b0, 1'b1);
        push_words(2);
        drain_words(2);

        // bad configurations: zero, top and just-too-large length, then offset and mask at their top
        configure(0, 0, 0, 1'b0, 1'b0);
        push_words(1);
        configure(15, 0, 0, 1'b1, 1'b1);
        drain_words(1);
        configure(LOG_W'(MAX_LOG_BLOCK + 1), 0, 0, 1'b0, 1'b1);
        push_words(1);
        configure(LOG_W'(MAX_LOG_BLOCK), 15'h7fff, 0, 1'b0, 1'b0);
        push_words(1);
        configure(LOG_W'(MAX_LOG_BLOCK), 0, 15'h7fff, 1'b1, 1'b0);
        drain_words(1);

        // shrinking the block under a partial fill completes it on the next push
        configure(3, 0, 0, 1'b0, 1'b0);
        push_words(5);
        configure(2, 0, 0, 1'b0, 1'b0);
        push_words(1);
        drain_words(2);
        // shrinking again leaves the emit position past the end: pending block ends
        configure(1, 0, 0, 1'b0, 1'b0);
        drain_words(1);

        // random phases, each with fresh registers over whatever state is left
        target = sent + 380;
        while (sent < target)
        begin
            lb   = ($urandom_range(0, 7) == 0) ? LOG_W'($urandom_range(5, TOP_LOG))
                                               : LOG_W'($urandom_range(1, 4));
            n    = 1 << lb;
            off  = pick_below(n);
            mask = pick_below(n);
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       lb = '0;
                    1:       lb = LOG_W'($urandom_range(MAX_LOG_BLOCK + 1, 15));
                    2:       off = IDX_W'($urandom_range(n, 32767));
                    default: mask = IDX_W'($urandom_range(n, 32767));
                endcase
                configure(lb, off, mask, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                repeat (3) send_item(1'($urandom_range(0, 1)), pick_word());
                continue;
            end
            configure(lb, off, mask, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    // whole blocks, a stray drain now and then
                    blocks = (lb > 4) ? 1 : $urandom_range(1, 3);
                    repeat (blocks * n)
                    begin
                        if ($urandom_range(0, 15) == 0)
                            drain_words(1);
                        push_words(1);
                    end
                    if ($urandom_range(0, 1) == 0)
                        drain_pending();
                end
                6, 7:
                    repeat ($urandom_range(4, 20))
                        send_item($urandom_range(0, 3) == 0 ? CMD_DRAIN : CMD_PUSH,
                                  pick_word());
                default:
                begin
                    // broken block: a drain catches it partly full
                    drain_pending();
                    push_words($urandom_range(1, n - 1));
                    drain_words(2);
                end
            endcase
        end

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (sb.outstanding() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
hdl/sxbp_pkg.sv
hdl/signed_xor_block_permute_core.sv
tb/testbench.sv
